### rtl/srv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types, constants and arithmetic helpers of the stereo reverb.
// ----------------------------------------------------------------------------
package srv_pkg;

  localparam int unsigned SW     = 16;  // sample width
  localparam int unsigned DW     = 24;  // store width, 8 fraction bits
  localparam int unsigned FRAC   = 8;
  localparam int unsigned ACC_W  = 28;  // intermediate sums
  localparam int unsigned MA_W   = 26;  // multiplier operand a
  localparam int unsigned MB_W   = 18;  // multiplier operand b
  localparam int unsigned PW     = MA_W + MB_W;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned STEP_W = 5;

  localparam int unsigned SIDE_LEFT  = 0;
  localparam int unsigned SIDE_RIGHT = 1;

  // (150 / 44100)^2 in Q0.32, rounded
  localparam logic signed [MB_W-1:0] HP_COEF = 18'sd49690;

  localparam int unsigned LINE_LEN [2][6] = '{
    '{1309, 1635, 1811, 1926, 220, 74},
    '{934, 1819, 624, 690, 141, 59}
  };
  localparam int unsigned COMB_OFF [2][4] = '{
    '{0, 1309, 2944, 4755},
    '{0, 934, 2753, 3377}
  };
  localparam int unsigned COMB_DEPTH [2] = '{6681, 4067};
  localparam int unsigned AP_DEPTH   [2] = '{294, 200};

  // clearing pass covers the deepest store
  localparam int unsigned CLR_LEN = 6681;
  localparam int unsigned CLR_W   = $clog2(CLR_LEN);

  localparam logic [3:0] CFG_COMB_A = 4'd0;
  localparam logic [3:0] CFG_COMB_B = 4'd1;
  localparam logic [3:0] CFG_COMB_C = 4'd2;
  localparam logic [3:0] CFG_COMB_D = 4'd3;
  localparam logic [3:0] CFG_AP_A   = 4'd4;
  localparam logic [3:0] CFG_AP_B   = 4'd5;
  localparam logic [3:0] CFG_DAMP   = 4'd6;
  localparam logic [3:0] CFG_WET    = 4'd7;

  // sequencer steps of one lane
  localparam logic [STEP_W-1:0] STP_ADV  = 5'd0;
  localparam logic [STEP_W-1:0] STP_HP   = 5'd1;
  localparam logic [STEP_W-1:0] STP_FEED = 5'd2;
  localparam logic [STEP_W-1:0] STP_T0   = 5'd3;
  localparam logic [STEP_W-1:0] STP_T1   = 5'd4;
  localparam logic [STEP_W-1:0] STP_D0   = 5'd5;
  localparam logic [STEP_W-1:0] STP_D1   = 5'd6;
  localparam logic [STEP_W-1:0] STP_T2   = 5'd7;
  localparam logic [STEP_W-1:0] STP_T3   = 5'd8;
  localparam logic [STEP_W-1:0] STP_D2   = 5'd9;
  localparam logic [STEP_W-1:0] STP_D3   = 5'd10;
  localparam logic [STEP_W-1:0] STP_Z    = 5'd11;
  localparam logic [STEP_W-1:0] STP_ACC  = 5'd12;
  localparam logic [STEP_W-1:0] STP_Z2   = 5'd13;
  localparam logic [STEP_W-1:0] STP_GBZ  = 5'd14;
  localparam logic [STEP_W-1:0] STP_REV  = 5'd15;
  localparam logic [STEP_W-1:0] STP_MIX  = 5'd16;
  localparam logic [STEP_W-1:0] STP_OUT  = 5'd17;

  typedef struct packed {
    logic signed [SW-1:0] left_in;
    logic signed [SW-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;
  } out_t;

  typedef struct packed {
    logic bypass;
    in_t  sample;
  } qent_t;

  typedef struct packed {
    logic signed [15:0] comb_gain_a;
    logic signed [15:0] comb_gain_b;
    logic signed [15:0] comb_gain_c;
    logic signed [15:0] comb_gain_d;
    logic signed [15:0] allpass_gain_a;
    logic signed [15:0] allpass_gain_b;
    logic [14:0]        damping_coef;
    logic [6:0]         wet_gain;
  } cfg_t;

  typedef struct packed {
    logic              run;
    logic [STEP_W-1:0] step;
    logic              clr;
    logic [CLR_W-1:0]  clr_addr;
  } lane_ctl_t;

  // round half up by s bits, result narrowed to the accumulator width
  function automatic logic signed [ACC_W-1:0] rnd_acc(input logic signed [PW-1:0] p,
                                                       input int unsigned s);
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] r;
    half    = '0;
    half[s-1] = 1'b1;
    r       = (p + half) >>> s;
    return r[ACC_W-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_store(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:DW-1] == '0 || v[ACC_W-1:DW-1] == '1) begin
      return v[DW-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SW-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:SW-1] == '0 || v[ACC_W-1:SW-1] == '1) begin
      return v[SW-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_store(input logic signed [DW-1:0] v);
    return {{(ACC_W-DW){v[DW-1]}}, v};
  endfunction

endpackage

### rtl/srv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srv_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/srv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_front
// Input side: takes beats, marks bypass items, two-entry queue to the back.
// ----------------------------------------------------------------------------
module srv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srv_pkg::in_t        in_data_i,
  input  logic [6:0]          wet_gain_i,
  input  logic                busy_i,
  output logic                q_valid_o,
  output srv_pkg::qent_t      q_ent_o,
  input  logic                q_pop_i
);

  srv_pkg::qent_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;

  assign in_stall_o = (cnt_q == 2'd2) || busy_i;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_ent_o    = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q].bypass <= (wet_gain_i == 7'd0);
      ent_q[wr_ptr_q].sample <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

### rtl/srv_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_lane
// One channel: high-pass, four damped combs, two allpasses, wet mix.
// ----------------------------------------------------------------------------
module srv_lane #(
  parameter int unsigned SIDE = srv_pkg::SIDE_LEFT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srv_pkg::lane_ctl_t               ctl_i,
  input  srv_pkg::cfg_t                    cfg_i,
  input  logic signed [srv_pkg::SW-1:0]    x_i,
  input  logic signed [srv_pkg::DW-1:0]    rev_other_i,
  output logic signed [srv_pkg::DW-1:0]    rev_o,
  output logic signed [srv_pkg::SW-1:0]    out_o
);

  localparam int unsigned DW    = srv_pkg::DW;
  localparam int unsigned ACC_W = srv_pkg::ACC_W;
  localparam int unsigned MA_W  = srv_pkg::MA_W;
  localparam int unsigned MB_W  = srv_pkg::MB_W;
  localparam int unsigned POS_W = srv_pkg::POS_W;
  localparam int unsigned CD    = srv_pkg::COMB_DEPTH[SIDE];
  localparam int unsigned AD    = srv_pkg::AP_DEPTH[SIDE];
  localparam int unsigned CAW   = $clog2(CD);
  localparam int unsigned AAW   = $clog2(AD);

  logic [POS_W-1:0]          pos_q [6];
  logic [POS_W-1:0]          pos_nx [6];
  logic signed [DW-1:0]      h_q, feed_q, y1_q, y2_q, z_q, z2_q, rev_q;
  logic signed [DW-1:0]      d_q [4];
  logic signed [MA_W-1:0]    t_q;
  logic signed [ACC_W-1:0]   sum_q, acc_q;
  logic signed [srv_pkg::PW-1:0] prod_q;
  logic signed [srv_pkg::SW-1:0] out_q;

  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [ACC_W-1:0]   r15, r32, r14, xe, xs, tsum, hsum, fsum;
  logic signed [DW-1:0]      dn, rd_comb, rd_ap;
  logic [1:0]                li;
  logic [CAW-1:0]            c_raddr, c_waddr;
  logic [DW-1:0]             c_wdata;
  logic                      c_we;
  logic [AAW-1:0]            a_raddr, a_waddr, a_p4, a_p5;
  logic [DW-1:0]             a_wdata;
  logic                      a_we;

  assign r15 = srv_pkg::rnd_acc(prod_q, 15);
  assign r32 = srv_pkg::rnd_acc(prod_q, 32);
  assign r14 = srv_pkg::rnd_acc(prod_q, 14);
  assign xe  = {{(ACC_W-srv_pkg::SW-srv_pkg::FRAC){x_i[srv_pkg::SW-1]}}, x_i,
                {srv_pkg::FRAC{1'b0}}};
  assign xs  = {{(ACC_W-srv_pkg::SW){x_i[srv_pkg::SW-1]}}, x_i};
  assign hsum = xe - srv_pkg::ext_store(h_q);
  assign fsum = (hsum + ACC_W'(2)) >>> 2;
  assign a_p4 = pos_q[4][AAW-1:0];
  assign a_p5 = AAW'(srv_pkg::LINE_LEN[SIDE][4]) + pos_q[5][AAW-1:0];

  // comb line handled in this step
  always_comb begin
    case (ctl_i.step)
      srv_pkg::STP_T0, srv_pkg::STP_D0:                   li = 2'd0;
      srv_pkg::STP_T1, srv_pkg::STP_D1, srv_pkg::STP_FEED: li = 2'd1;
      srv_pkg::STP_T2, srv_pkg::STP_D2:                   li = 2'd2;
      srv_pkg::STP_T3, srv_pkg::STP_D3:                   li = 2'd3;
      default:                                            li = 2'd0;
    endcase
  end

  assign tsum = srv_pkg::ext_store(feed_q) + r15 - srv_pkg::ext_store(d_q[li]);
  assign dn   = srv_pkg::sat_store(srv_pkg::ext_store(d_q[li]) + r15);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      if (pos_q[k] + POS_W'(1) >= POS_W'(srv_pkg::LINE_LEN[SIDE][k])) begin
        pos_nx[k] = '0;
      end else begin
        pos_nx[k] = pos_q[k] + POS_W'(1);
      end
    end
  end

  // multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl_i.step)
      srv_pkg::STP_ADV: begin
        ma = hsum[MA_W-1:0];
        mb = srv_pkg::HP_COEF;
      end
      srv_pkg::STP_FEED: begin
        ma = {{(MA_W-DW){rd_comb[DW-1]}}, rd_comb};
        mb = {{(MB_W-16){cfg_i.comb_gain_a[15]}}, cfg_i.comb_gain_a};
      end
      srv_pkg::STP_T0: begin
        ma = {{(MA_W-DW){rd_comb[DW-1]}}, rd_comb};
        mb = {{(MB_W-16){cfg_i.comb_gain_b[15]}}, cfg_i.comb_gain_b};
      end
      srv_pkg::STP_D1: begin
        ma = {{(MA_W-DW){rd_comb[DW-1]}}, rd_comb};
        mb = {{(MB_W-16){cfg_i.comb_gain_c[15]}}, cfg_i.comb_gain_c};
      end
      srv_pkg::STP_T2: begin
        ma = {{(MA_W-DW){rd_comb[DW-1]}}, rd_comb};
        mb = {{(MB_W-16){cfg_i.comb_gain_d[15]}}, cfg_i.comb_gain_d};
      end
      srv_pkg::STP_T1, srv_pkg::STP_D0, srv_pkg::STP_T3, srv_pkg::STP_D2: begin
        ma = t_q;
        mb = {{(MB_W-15){1'b0}}, cfg_i.damping_coef};
      end
      srv_pkg::STP_D3: begin
        ma = {{(MA_W-DW){y1_q[DW-1]}}, y1_q};
        mb = {{(MB_W-16){cfg_i.allpass_gain_a[15]}}, cfg_i.allpass_gain_a};
      end
      srv_pkg::STP_Z: begin
        ma = {{(MA_W-DW){y2_q[DW-1]}}, y2_q};
        mb = {{(MB_W-16){cfg_i.allpass_gain_b[15]}}, cfg_i.allpass_gain_b};
      end
      srv_pkg::STP_ACC: begin
        ma = {{(MA_W-DW){z_q[DW-1]}}, z_q};
        mb = {{(MB_W-16){cfg_i.allpass_gain_a[15]}}, cfg_i.allpass_gain_a};
      end
      srv_pkg::STP_GBZ: begin
        ma = {{(MA_W-DW){z2_q[DW-1]}}, z2_q};
        mb = {{(MB_W-16){cfg_i.allpass_gain_b[15]}}, cfg_i.allpass_gain_b};
      end
      srv_pkg::STP_MIX: begin
        ma = {{(MA_W-DW){rev_other_i[DW-1]}}, rev_other_i};
        mb = {{(MB_W-7){1'b0}}, cfg_i.wet_gain};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // memory ports; reads are issued in the step before their data is used
  always_comb begin
    c_raddr = '0;
    a_raddr = '0;
    case (ctl_i.step)
      srv_pkg::STP_HP:   c_raddr = CAW'(srv_pkg::COMB_OFF[SIDE][0]) + CAW'(pos_q[0]);
      srv_pkg::STP_FEED: c_raddr = CAW'(srv_pkg::COMB_OFF[SIDE][1]) + CAW'(pos_q[1]);
      srv_pkg::STP_D0:   c_raddr = CAW'(srv_pkg::COMB_OFF[SIDE][2]) + CAW'(pos_q[2]);
      srv_pkg::STP_D1:   c_raddr = CAW'(srv_pkg::COMB_OFF[SIDE][3]) + CAW'(pos_q[3]);
      srv_pkg::STP_T3:   a_raddr = a_p4;
      srv_pkg::STP_D2:   a_raddr = a_p5;
      default: begin
        c_raddr = '0;
        a_raddr = '0;
      end
    endcase

    c_we    = 1'b0;
    c_waddr = CAW'(srv_pkg::COMB_OFF[SIDE][li]) + CAW'(pos_q[li]);
    c_wdata = dn;
    a_we    = 1'b0;
    a_waddr = a_p4;
    a_wdata = srv_pkg::sat_store(r15 + srv_pkg::ext_store(srv_pkg::sat_store(sum_q)));
    if (ctl_i.clr) begin
      c_we    = (ctl_i.clr_addr < srv_pkg::CLR_W'(CD));
      c_waddr = ctl_i.clr_addr[CAW-1:0];
      c_wdata = '0;
      a_we    = (ctl_i.clr_addr < srv_pkg::CLR_W'(AD));
      a_waddr = ctl_i.clr_addr[AAW-1:0];
      a_wdata = '0;
    end else if (ctl_i.run) begin
      case (ctl_i.step)
        srv_pkg::STP_D0, srv_pkg::STP_D1, srv_pkg::STP_D2, srv_pkg::STP_D3: c_we = 1'b1;
        srv_pkg::STP_Z: a_we = 1'b1;
        srv_pkg::STP_Z2: begin
          a_we    = 1'b1;
          a_waddr = a_p5;
          a_wdata = srv_pkg::sat_store(acc_q - r15);
        end
        default: begin
          c_we = 1'b0;
          a_we = 1'b0;
        end
      endcase
    end
  end

  srv_ram #(.WIDTH(DW), .DEPTH(CD)) u_comb_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (rd_comb)
  );

  srv_ram #(.WIDTH(DW), .DEPTH(AD)) u_ap_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (rd_ap)
  );

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
      for (int k = 0; k < 6; k++) begin
        pos_q[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        d_q[k] <= '0;
      end
    end else if (ctl_i.run) begin
      case (ctl_i.step)
        srv_pkg::STP_ADV: pos_q <= pos_nx;
        srv_pkg::STP_HP:  h_q <= srv_pkg::sat_store(srv_pkg::ext_store(h_q) + r32);
        srv_pkg::STP_D0, srv_pkg::STP_D1, srv_pkg::STP_D2, srv_pkg::STP_D3: d_q[li] <= dn;
        default: h_q <= h_q;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (ctl_i.run) begin
      case (ctl_i.step)
        srv_pkg::STP_FEED: feed_q <= srv_pkg::sat_store(fsum);
        srv_pkg::STP_T0, srv_pkg::STP_T1, srv_pkg::STP_T2, srv_pkg::STP_T3:
          t_q <= tsum[MA_W-1:0];
        srv_pkg::STP_D0: sum_q <= srv_pkg::ext_store(dn);
        srv_pkg::STP_D1: sum_q <= sum_q + srv_pkg::ext_store(dn);
        srv_pkg::STP_D2: begin
          sum_q <= sum_q + srv_pkg::ext_store(dn);
          y1_q  <= rd_ap;
        end
        srv_pkg::STP_D3: begin
          sum_q <= sum_q + srv_pkg::ext_store(dn);
          y2_q  <= rd_ap;
        end
        srv_pkg::STP_Z:   z_q   <= a_wdata;
        srv_pkg::STP_ACC: acc_q <= r15 + srv_pkg::ext_store(y1_q);
        srv_pkg::STP_Z2:  z2_q  <= srv_pkg::sat_store(acc_q - r15);
        srv_pkg::STP_REV: rev_q <= srv_pkg::sat_store(srv_pkg::ext_store(y2_q) - r15);
        srv_pkg::STP_OUT: out_q <= srv_pkg::sat_sample(xs + r14);
        default: out_q <= out_q;
      endcase
    end
  end

  assign rev_o = rev_q;
  assign out_o = out_q;

endmodule

### rtl/srv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_back
// Sequencer for the two channel lanes, clearing pass and output register.
// ----------------------------------------------------------------------------
module srv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srv_pkg::cfg_t   cfg_i,
  input  logic            q_valid_i,
  input  srv_pkg::qent_t  q_ent_i,
  output logic            q_pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output srv_pkg::out_t   out_data_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e                         state_q, state_d;
  logic [srv_pkg::STEP_W-1:0]     step_q;
  logic [srv_pkg::CLR_W-1:0]      clr_q;
  srv_pkg::in_t                   cur_q;
  logic                           out_valid_q;
  srv_pkg::out_t                  out_q, out_d;
  logic                           out_free, out_load;
  srv_pkg::lane_ctl_t             ctl;
  logic signed [srv_pkg::DW-1:0]  rev_l, rev_r;
  logic signed [srv_pkg::SW-1:0]  lo, ro;

  assign out_free = !out_valid_q || !out_stall_i;
  assign busy_o   = (state_q == ST_CLEAR);

  assign ctl.run      = (state_q == ST_RUN);
  assign ctl.step     = step_q;
  assign ctl.clr      = (state_q == ST_CLEAR);
  assign ctl.clr_addr = clr_q;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    out_d    = '{left_out: lo, right_out: ro};
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == srv_pkg::CLR_W'(srv_pkg::CLR_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_ent_i.bypass) begin
            if (out_free) begin
              q_pop_o  = 1'b1;
              out_load = 1'b1;
              out_d    = '{left_out: q_ent_i.sample.left_in,
                           right_out: q_ent_i.sample.right_in};
            end
          end else begin
            q_pop_o = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (step_q == srv_pkg::STP_OUT) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + srv_pkg::CLR_W'(1);
      end
      if (state_q == ST_RUN) begin
        step_q <= step_q + srv_pkg::STEP_W'(1);
      end else begin
        step_q <= srv_pkg::STP_ADV;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_ent_i.sample;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  srv_lane #(.SIDE(srv_pkg::SIDE_LEFT)) u_lane_l (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_i       (cfg_i),
    .x_i         (cur_q.left_in),
    .rev_other_i (rev_r),
    .rev_o       (rev_l),
    .out_o       (lo)
  );

  srv_lane #(.SIDE(srv_pkg::SIDE_RIGHT)) u_lane_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_i       (cfg_i),
    .x_i         (cur_q.right_in),
    .rev_other_i (rev_l),
    .rev_o       (rev_r),
    .out_o       (ro)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/stereo_schroeder_reverb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_schroeder_reverb
// Throughput: the back processes one beat at a time, stepped by the 18-step
// lane sequencer with one multiplier per channel, while the front queues up
// to two more; bypass beats one per cycle while the back is idle and the
// output is not stalled. Reset: a clearing pass zeroes the delay stores;
// no input beat is taken meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module stereo_schroeder_reverb (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  srv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output srv_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  srv_pkg::cfg_t  cfg_q;
  logic           q_valid, q_pop, busy;
  srv_pkg::qent_t q_ent;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comb_gain_a    <= 16'sd30432;
      cfg_q.comb_gain_b    <= -16'sd29877;
      cfg_q.comb_gain_c    <= 16'sd29580;
      cfg_q.comb_gain_d    <= -16'sd29390;
      cfg_q.allpass_gain_a <= 16'sd32363;
      cfg_q.allpass_gain_b <= -16'sd32630;
      cfg_q.damping_coef   <= 15'd21728;
      cfg_q.wet_gain       <= 7'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        srv_pkg::CFG_COMB_A: cfg_q.comb_gain_a    <= cfg_data_i;
        srv_pkg::CFG_COMB_B: cfg_q.comb_gain_b    <= cfg_data_i;
        srv_pkg::CFG_COMB_C: cfg_q.comb_gain_c    <= cfg_data_i;
        srv_pkg::CFG_COMB_D: cfg_q.comb_gain_d    <= cfg_data_i;
        srv_pkg::CFG_AP_A:   cfg_q.allpass_gain_a <= cfg_data_i;
        srv_pkg::CFG_AP_B:   cfg_q.allpass_gain_b <= cfg_data_i;
        srv_pkg::CFG_DAMP:   cfg_q.damping_coef   <= cfg_data_i[14:0];
        srv_pkg::CFG_WET:    cfg_q.wet_gain       <= cfg_data_i[6:0];
        default:             cfg_q                <= cfg_q;
      endcase
    end
  end

  srv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .wet_gain_i (cfg_q.wet_gain),
    .busy_i     (busy),
    .q_valid_o  (q_valid),
    .q_ent_o    (q_ent),
    .q_pop_i    (q_pop)
  );

  srv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ent_i     (q_ent),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo reverb. Config phases are written while
// the block is idle, then directed and random stereo samples are streamed in
// with random gaps and output stalls. Every output beat is compared against a
// bit-true fixed-point model of the comb/allpass network kept here.
// ----------------------------------------------------------------------------
module tb;
  import srv_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES    = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  in_t  sample_q[$];
  out_t mix_q[$];
  int   errors = 0;
  bit   calm = 1'b0;
  int   results_seen = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  // model state
  int          comb_mem[2][6681];
  int          ap_mem[2][294];
  int unsigned line_pos[2][6];
  longint      damp_st[2][4];
  longint      hp_st[2];
  longint      comb_g[4];
  longint      ap_ga, ap_gb, damp_k, wet;

  stereo_schroeder_reverb u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic void model_write(logic [3:0] idx, logic [15:0] val);
    case (idx)
      CFG_COMB_A: comb_g[0] = longint'($signed(val));
      CFG_COMB_B: comb_g[1] = longint'($signed(val));
      CFG_COMB_C: comb_g[2] = longint'($signed(val));
      CFG_COMB_D: comb_g[3] = longint'($signed(val));
      CFG_AP_A:   ap_ga = longint'($signed(val));
      CFG_AP_B:   ap_gb = longint'($signed(val));
      CFG_DAMP:   damp_k = longint'(val[14:0]);
      CFG_WET:    wet = longint'(val[6:0]);
      default: ;
    endcase
  endfunction

  function automatic longint channel_reverb(longint x, int s);
    longint h, feed, sum, d, t, y1, y2, z, z2;
    int unsigned idx, p4, p5;
    h = hp_st[s];
    h = clamp(h + rnd_shift((x - h) * longint'(HP_COEF), 32), DW);
    hp_st[s] = h;
    feed = clamp(rnd_shift(x - h, 2), DW);
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      idx = COMB_OFF[s][i] + line_pos[s][i];
      d = damp_st[s][i];
      t = feed + rnd_shift(comb_g[i] * longint'(comb_mem[s][idx]), 15) - d;
      d = clamp(d + rnd_shift(t * damp_k, 15), DW);
      damp_st[s][i] = d;
      comb_mem[s][idx] = int'(d);
      sum += d;
    end
    sum = clamp(sum, DW);
    p4 = line_pos[s][4];
    p5 = LINE_LEN[s][4] + line_pos[s][5];
    y1 = ap_mem[s][p4];
    z = clamp(rnd_shift(ap_ga * y1, 15) + sum, DW);
    ap_mem[s][p4] = int'(z);
    y2 = ap_mem[s][p5];
    z2 = clamp(rnd_shift(ap_gb * y2, 15) + y1 - rnd_shift(ap_ga * z, 15), DW);
    ap_mem[s][p5] = int'(z2);
    return clamp(y2 - rnd_shift(ap_gb * z2, 15), DW);
  endfunction

  function automatic out_t predict_mix(in_t smp);
    out_t   o;
    longint l, r, rev_l, rev_r;
    l = longint'(smp.left_in);
    r = longint'(smp.right_in);
    if (wet == 0) begin
      o.left_out  = smp.left_in;
      o.right_out = smp.right_in;
      return o;
    end
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 6; j++) begin
        line_pos[s][j] = (line_pos[s][j] + 1 >= LINE_LEN[s][j]) ? 0 : line_pos[s][j] + 1;
      end
    end
    rev_r = channel_reverb(r <<< FRAC, SIDE_RIGHT);
    rev_l = channel_reverb(l <<< FRAC, SIDE_LEFT);
    o.left_out  = SW'(clamp(l + rnd_shift(rev_r * wet, 6 + FRAC), SW));
    o.right_out = SW'(clamp(r + rnd_shift(rev_l * wet, 6 + FRAC), SW));
    return o;
  endfunction

  // sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        mix_q.push_back(predict_mix(in_data));
      end
      if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
        in_valid <= 1'b1;
        in_data  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off after 200 results
  always @(posedge clk or negedge rst_n) begin
    out_t exp_beat;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_seen == 200) hold_left = HOLD_CYCLES;
        if (mix_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h", $realtime, out_data);
        end else begin
          exp_beat = mix_q.pop_front();
          if (exp_beat.left_out !== out_data.left_out) begin
            errors++;
            $display("%0t: left_out expected %0d actual %0d", $realtime,
                     exp_beat.left_out, out_data.left_out);
          end
          if (exp_beat.right_out !== out_data.right_out) begin
            errors++;
            $display("%0t: right_out expected %0d actual %0d", $realtime,
                     exp_beat.right_out, out_data.right_out);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && $urandom_range(99) < 19;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [3:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_write(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(posedge clk);
    while (sample_q.size() > 0 || in_valid || mix_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_gains(logic [15:0] ca, logic [15:0] cb, logic [15:0] cc,
                           logic [15:0] cd, logic [15:0] aa, logic [15:0] ab,
                           logic [15:0] dk, logic [15:0] wg);
    reg_write(CFG_COMB_A, ca);
    reg_write(CFG_COMB_B, cb);
    reg_write(CFG_COMB_C, cc);
    reg_write(CFG_COMB_D, cd);
    reg_write(CFG_AP_A, aa);
    reg_write(CFG_AP_B, ab);
    reg_write(CFG_DAMP, dk);
    reg_write(CFG_WET, wg);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(int n);
    in_t smp;
    for (int k = 0; k < n; k++) begin
      smp.left_in  = pick_sample();
      smp.right_in = pick_sample();
      sample_q.push_back(smp);
    end
  endtask

  task automatic push_directed;
    sample_q.push_back('{16'sh7fff, 16'sh7fff});
    sample_q.push_back('{-16'sh8000, -16'sh8000});
    sample_q.push_back('{16'sh7fff, -16'sh8000});
    sample_q.push_back('{-16'sh8000, 16'sh7fff});
    sample_q.push_back('{16'sh0000, 16'sh0000});
    sample_q.push_back('{16'sh0001, -16'sh0001});
    sample_q.push_back('{16'sh5555, 16'shaaaa});
  endtask

  initial begin
    model_write(CFG_COMB_A, 16'd30432);
    model_write(CFG_COMB_B, -16'sd29877);
    model_write(CFG_COMB_C, 16'd29580);
    model_write(CFG_COMB_D, -16'sd29390);
    model_write(CFG_AP_A, 16'd32363);
    model_write(CFG_AP_B, -16'sd32630);
    model_write(CFG_DAMP, 16'd21728);
    model_write(CFG_WET, 16'd0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // bypass at reset settings, state must stay frozen
    push_directed();
    drain();

    // reset gains, full wet; includes the long receiver hold-off
    reg_write(CFG_WET, 16'd64);
    push_directed();
    push_random(250);
    drain();

    // wet above nominal, no idling at all
    calm = 1'b1;
    reg_write(CFG_WET, 16'h007f);
    push_directed();
    push_random(120);
    drain();
    calm = 1'b0;

    // extreme gains, darkest damping; out-of-range indexes are ignored
    set_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
              16'h0000, 16'd1);
    reg_write(4'd8, 16'hffff);
    reg_write(4'd15, 16'h1234);
    push_random(120);
    drain();

    // brightest damping, upper bits of damping and wet data dropped
    set_gains(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
              16'hffff, 16'hff80 | 16'd40);
    push_directed();
    push_random(120);
    drain();

    // back to bypass mid-run, then random gains
    reg_write(CFG_WET, 16'h0080);
    push_random(40);
    drain();
    set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'd20);
    push_random(120);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
